[rtl/bffa_pkg.sv]
// bffa_pkg: shared types and constants of the bitmap first-fit block allocator
// field widths, operation and status codes, register indexes, controller states
// no dependencies
`default_nettype none

package bffa_pkg;

    // item field widths
    localparam int ACTION_W  = 2;
    localparam int LENGTH_W  = 23;
    localparam int INDEX_W   = 10;
    localparam int STATUS_W  = 2;
    localparam int FIRST_W   = 10;
    localparam int FREE_W    = 11;

    // configuration register widths and reset values
    localparam int BSIZE_W   = 13;
    localparam int BCOUNT_W  = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [BSIZE_W-1:0]  BSIZE_RST  = 13'd64;
    localparam logic [BCOUNT_W-1:0] BCOUNT_RST = 11'd1024;

    // packed stream widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    // block count need: quotient plus round-up
    localparam int NEED_W = LENGTH_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIZE  = 1'd0,
        CFG_BLOCK_COUNT = 1'd1
    } cfg_idx_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_COUNT   = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_MARK,
        S_COUNT,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

[rtl/bffa_ram.sv]
// bffa_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module bffa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/bffa_div.sv]
// bffa_div: restoring divider, one quotient bit a cycle, rounds the quotient up
// depends on bffa_pkg
`default_nettype none

module bffa_div (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [bffa_pkg::LENGTH_W-1:0]  dividend,
    input  wire logic [bffa_pkg::BSIZE_W-1:0]   divisor,
    output logic                                done,
    output logic      [bffa_pkg::NEED_W-1:0]    need
);

    localparam int LW = bffa_pkg::LENGTH_W;
    localparam int DW = bffa_pkg::BSIZE_W;
    localparam int CW = $clog2(LW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [LW-1:0] q_reg, q_next;
    logic [DW-1:0] r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign trial = {r_reg, q_reg[LW-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign ge    = trial >= {1'b0, d_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end else if (busy_reg) begin
            r_next   = ge ? diff[DW-1:0] : trial[DW-1:0];
            q_next   = {q_reg[LW-2:0], ge};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(LW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign need = {1'b0, q_reg} + bffa_pkg::NEED_W'(r_reg != '0);

endmodule

`default_nettype wire

[rtl/bitmap_first_fit_block_allocator.sv]
// bitmap_first_fit_block_allocator: first-fit contiguous block allocator over a usage bitmap
// depends on bffa_pkg, bffa_ram and bffa_div
//
// usage:
//   requests come in on the s_ stream, one item each: s_tuser holds the action
//   (allocate, release, count free), s_tdata the byte length and block index.
//   each request gives exactly one result item on the m_ stream: m_tuser holds
//   the status, m_tdata the run start and the free block count after the op.
//   block size and block count are written through the cfg_ channel; cfg_ready is
//   always high; the user must write them only while the block is idle (not enforced).
// sequence, with n the effective block count:
//   allocate: divider, first-fit scan of up to n entries, marking of the run, free
//   count over n entries, result. a failed allocate skips only the marking;
//   release, count and empty requests skip the divider, scan and marking. every
//   pass walks the bitmap ram one entry a cycle through its single read port.
// reset: synchronous, aresetn low. afterward a clearing pass writes every bitmap
//   entry free, with s_tready low.
// stall: the result sits in an output register, so the next request is taken
//   while it waits; a finished request holds until that register is free.
`default_nettype none

module bitmap_first_fit_block_allocator #(
    parameter int MAX_BLOCKS = 1024
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bffa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bffa_pkg::CFG_DATA_W-1:0]    cfg_data,
    // request stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // tdata: length_bytes[22:0], block_index[32:23], zero pad
    input  wire logic [bffa_pkg::S_TDATA_W-1:0]     s_tdata,
    // tuser: action[1:0]
    input  wire logic [bffa_pkg::S_TUSER_W-1:0]     s_tuser,
    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // tdata: first_block[9:0], free_blocks[20:10], zero pad
    output logic      [bffa_pkg::M_TDATA_W-1:0]     m_tdata,
    // tuser: status[1:0]
    output logic      [bffa_pkg::M_TUSER_W-1:0]     m_tuser
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int LW = $clog2(MAX_BLOCKS + 1);

    // configuration
    logic [bffa_pkg::BSIZE_W-1:0]  bsize_reg;
    logic [bffa_pkg::BCOUNT_W-1:0] bcount_reg;
    logic [bffa_pkg::BSIZE_W-1:0]  bsize_eff;
    logic [LW-1:0]                 n_live;

    // request fields
    logic [bffa_pkg::LENGTH_W-1:0] in_length;
    logic [bffa_pkg::INDEX_W-1:0]  in_index;
    logic [bffa_pkg::ACTION_W-1:0] in_action;

    // controller
    bffa_pkg::state_t              state_reg, state_next;
    logic [LW-1:0]                 ra_reg, ra_next;     // read address being issued
    logic [AW-1:0]                 pa_reg, pa_next;     // address of data now on rd_data
    logic                          pv_reg, pv_next;     // rd_data holds a live entry
    logic [LW-1:0]                 run_reg, run_next;
    logic [LW-1:0]                 cnt_reg, cnt_next;
    logic [LW-1:0]                 left_reg, left_next;
    logic [AW-1:0]                 wa_reg, wa_next;
    logic [AW-1:0]                 start_reg, start_next;
    logic [bffa_pkg::NEED_W-1:0]   need_reg, need_next;
    bffa_pkg::status_t             status_reg, status_next;
    logic [LW-1:0]                 run_new;
    logic [LW-1:0]                 start_calc;

    // output register
    logic                          m_valid_reg, m_valid_next;
    bffa_pkg::status_t             o_status_reg, o_status_next;
    logic [bffa_pkg::FIRST_W-1:0]  o_first_reg, o_first_next;
    logic [bffa_pkg::FREE_W-1:0]   o_free_reg, o_free_next;

    // memory ports
    logic                          mem_we;
    logic [AW-1:0]                 mem_wa;
    logic                          mem_wd;
    logic                          mem_re;
    logic [AW-1:0]                 mem_ra;
    logic [0:0]                    mem_rd;

    // divider
    logic                          div_start;
    logic                          div_done;
    logic [bffa_pkg::NEED_W-1:0]   div_need;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == bffa_pkg::S_IDLE);

    assign in_length = s_tdata[bffa_pkg::LENGTH_W-1:0];
    assign in_index  = s_tdata[bffa_pkg::LENGTH_W +: bffa_pkg::INDEX_W];
    assign in_action = s_tuser[bffa_pkg::ACTION_W-1:0];

    // zero block size counts as one byte
    assign bsize_eff = (bsize_reg == '0) ? bffa_pkg::BSIZE_W'(1) : bsize_reg;

    // block count clamps to the map depth
    always_comb begin
        if (32'(bcount_reg) > 32'(MAX_BLOCKS)) begin
            n_live = LW'(MAX_BLOCKS);
        end else begin
            n_live = LW'(bcount_reg);
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bsize_reg  <= bffa_pkg::BSIZE_RST;
            bcount_reg <= bffa_pkg::BCOUNT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                bffa_pkg::CFG_BLOCK_SIZE: begin
                    bsize_reg <= cfg_data[bffa_pkg::BSIZE_W-1:0];
                end
                bffa_pkg::CFG_BLOCK_COUNT: begin
                    bcount_reg <= cfg_data[bffa_pkg::BCOUNT_W-1:0];
                end
                default: begin
                    bsize_reg <= bsize_reg;
                end
            endcase
        end
    end

    bffa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (in_length),
        .divisor  (bsize_eff),
        .done     (div_done),
        .need     (div_need)
    );

    // usage bitmap, one bit per block, set means used
    bffa_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BLOCKS)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_wa),
        .wr_data (mem_wd),
        .rd_en   (mem_re),
        .rd_addr (mem_ra),
        .rd_data (mem_rd)
    );

    // running free-run length including the entry on rd_data
    assign run_new    = mem_rd[0] ? '0 : run_reg + LW'(1);
    // start of the run that ends at pa_reg; need fits since need <= run_new
    assign start_calc = LW'(pa_reg) + LW'(1) - LW'(need_reg);

    always_comb begin
        state_next    = state_reg;
        ra_next       = ra_reg;
        pa_next       = pa_reg;
        pv_next       = pv_reg;
        run_next      = run_reg;
        cnt_next      = cnt_reg;
        left_next     = left_reg;
        wa_next       = wa_reg;
        start_next    = start_reg;
        need_next     = need_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        o_status_next = o_status_reg;
        o_first_next  = o_first_reg;
        o_free_next   = o_free_reg;
        mem_we        = 1'b0;
        mem_wa        = '0;
        mem_wd        = 1'b0;
        mem_re        = 1'b0;
        mem_ra        = '0;
        div_start     = 1'b0;

        case (state_reg)
            bffa_pkg::S_CLEAR: begin
                // mark every block free after reset
                mem_we  = 1'b1;
                mem_wa  = ra_reg[AW-1:0];
                ra_next = ra_reg + LW'(1);
                if (ra_reg == LW'(MAX_BLOCKS - 1)) begin
                    state_next = bffa_pkg::S_IDLE;
                end
            end

            bffa_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    status_next = bffa_pkg::ST_OK;
                    start_next  = '0;
                    ra_next     = '0;
                    pv_next     = 1'b0;
                    cnt_next    = '0;
                    run_next    = '0;
                    state_next  = bffa_pkg::S_COUNT;
                    case (in_action)
                        bffa_pkg::ACT_ALLOC: begin
                            if (in_length == '0) begin
                                status_next = bffa_pkg::ST_EMPTY;
                            end else begin
                                div_start  = 1'b1;
                                state_next = bffa_pkg::S_DIV;
                            end
                        end
                        bffa_pkg::ACT_RELEASE: begin
                            if (32'(in_index) < 32'(n_live)) begin
                                mem_we = 1'b1;
                                mem_wa = AW'(in_index);
                                mem_wd = 1'b0;
                            end else begin
                                status_next = bffa_pkg::ST_RANGE;
                            end
                        end
                        default: begin
                            // count, and the unused code, change nothing
                            state_next = bffa_pkg::S_COUNT;
                        end
                    endcase
                end
            end

            bffa_pkg::S_DIV: begin
                if (div_done) begin
                    need_next  = div_need;
                    state_next = bffa_pkg::S_SCAN;
                end
            end

            bffa_pkg::S_SCAN: begin
                // first fit: walk upward, read one entry a cycle
                pv_next = 1'b0;
                if (ra_reg < n_live) begin
                    mem_re  = 1'b1;
                    mem_ra  = ra_reg[AW-1:0];
                    pa_next = ra_reg[AW-1:0];
                    ra_next = ra_reg + LW'(1);
                    pv_next = 1'b1;
                end
                if (pv_reg) begin
                    run_next = run_new;
                    if (32'(run_new) >= 32'(need_reg)) begin
                        start_next = AW'(start_calc);
                        wa_next    = AW'(start_calc);
                        left_next  = LW'(need_reg);
                        state_next = bffa_pkg::S_MARK;
                    end
                end else if (ra_reg >= n_live) begin
                    status_next = bffa_pkg::ST_NO_SPACE;
                    ra_next     = '0;
                    cnt_next    = '0;
                    state_next  = bffa_pkg::S_COUNT;
                end
            end

            bffa_pkg::S_MARK: begin
                mem_we    = 1'b1;
                mem_wa    = wa_reg;
                mem_wd    = 1'b1;
                wa_next   = wa_reg + AW'(1);
                left_next = left_reg - LW'(1);
                if (left_reg == LW'(1)) begin
                    ra_next    = '0;
                    pv_next    = 1'b0;
                    cnt_next   = '0;
                    state_next = bffa_pkg::S_COUNT;
                end
            end

            bffa_pkg::S_COUNT: begin
                pv_next = 1'b0;
                if (ra_reg < n_live) begin
                    mem_re  = 1'b1;
                    mem_ra  = ra_reg[AW-1:0];
                    pa_next = ra_reg[AW-1:0];
                    ra_next = ra_reg + LW'(1);
                    pv_next = 1'b1;
                end
                if (pv_reg) begin
                    if (!mem_rd[0]) begin
                        cnt_next = cnt_reg + LW'(1);
                    end
                end else if (ra_reg >= n_live) begin
                    state_next = bffa_pkg::S_DONE;
                end
            end

            bffa_pkg::S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    o_status_next = status_reg;
                    o_first_next  = bffa_pkg::FIRST_W'(start_reg);
                    o_free_next   = bffa_pkg::FREE_W'(cnt_reg);
                    state_next    = bffa_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = bffa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bffa_pkg::S_CLEAR;
            ra_reg      <= '0;
            pv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ra_reg      <= ra_next;
            pv_reg      <= pv_next;
            m_valid_reg <= m_valid_next;
        end
        pa_reg       <= pa_next;
        run_reg      <= run_next;
        cnt_reg      <= cnt_next;
        left_reg     <= left_next;
        wa_reg       <= wa_next;
        start_reg    <= start_next;
        need_reg     <= need_next;
        status_reg   <= status_next;
        o_status_reg <= o_status_next;
        o_first_reg  <= o_first_next;
        o_free_reg   <= o_free_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_status_reg;
    assign m_tdata  = {3'b000, o_free_reg, o_first_reg};

endmodule

`default_nettype wire

[verif/bitmap_first_fit_block_allocator_tb.sv]
// testbench for bitmap_first_fit_block_allocator: directed and random allocate, release and
// count requests under several block size and block count settings, checked against a
// behavioral model of the usage map; depends on bffa_pkg and the allocator rtl
`timescale 1ns / 100ps

module bitmap_first_fit_block_allocator_tb;
    import bffa_pkg::*;

    localparam int MAP_DEPTH = 1024;
    localparam int PAD_W = S_TDATA_W - INDEX_W - LENGTH_W;
    // action code the block does not define, answered like a count
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    // worst case request: divider, scan, marking and free count over a full map
    localparam int DRAIN_CYCLES = 3 * MAP_DEPTH + 64;
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int LONG_HOLD = 400;
    localparam int NUM_PHASES = 5;

    typedef struct packed {
        status_t              status;
        logic [FIRST_W-1:0]   first_blk;
        logic [FREE_W-1:0]    free_cnt;
    } alloc_result_t;

    // usage map model plus the queue of results still owed by the block
    class bitmap_scoreboard;
        bit            taken [MAP_DEPTH];
        int unsigned   bsize;
        int unsigned   bcount;
        alloc_result_t pending[$];
        int            errors;
        int            checked;
        int            status_seen [4];

        function new();
            foreach (taken[k]) taken[k] = 1'b0;
            bsize = BSIZE_RST;
            bcount = BCOUNT_RST;
            errors = 0;
            checked = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_BLOCK_SIZE)
                bsize = val[BSIZE_W-1:0];
            else
                bcount = val[BCOUNT_W-1:0];
        endfunction

        function int unsigned live_count();
            return (bcount > MAP_DEPTH) ? MAP_DEPTH : bcount;
        endfunction

        function int unsigned free_count();
            int unsigned n;
            n = 0;
            for (int k = 0; k < live_count(); k++)
                if (!taken[k]) n++;
            return n;
        endfunction

        // a used block below the live count when one turns up in a few tries
        function int unsigned pick_used(int unsigned n);
            int unsigned k;
            k = $urandom_range(0, n - 1);
            for (int tries = 0; tries < 16 && !taken[k]; tries++)
                k = $urandom_range(0, n - 1);
            return k;
        endfunction

        function void predict_request(logic [ACTION_W-1:0] act, logic [LENGTH_W-1:0] len,
                                      logic [INDEX_W-1:0] idx);
            alloc_result_t r;
            int unsigned   n, bs, need, run, start;
            bit            found;
            n = live_count();
            r.status = ST_OK;
            r.first_blk = '0;
            if (act == ACT_ALLOC) begin
                if (len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    bs = (bsize == 0) ? 1 : bsize;
                    need = (len + bs - 1) / bs;
                    run = 0;
                    found = 1'b0;
                    start = 0;
                    // first fit from block 0 upward
                    for (int k = 0; k < n && !found; k++) begin
                        run = taken[k] ? 0 : run + 1;
                        if (run >= need) begin
                            start = k + 1 - need;
                            found = 1'b1;
                        end
                    end
                    if (found) begin
                        for (int k = start; k < start + need; k++) taken[k] = 1'b1;
                        r.first_blk = start[FIRST_W-1:0];
                    end else begin
                        r.status = ST_NO_SPACE;
                    end
                end
            end else if (act == ACT_RELEASE) begin
                if (idx < n)
                    taken[idx] = 1'b0;
                else
                    r.status = ST_RANGE;
            end
            r.free_cnt = free_count();
            pending.push_back(r);
        endfunction

        task report(string what, int got, int want);
            errors++;
            // keep the log bounded when the block is badly off
            if (errors <= 200)
                $display("mismatch at result %0d: %s got %0d expected %0d",
                         checked, what, got, want);
        endtask

        task check_result(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user);
            alloc_result_t want;
            checked++;
            if (pending.size() == 0) begin
                report("result with no request waiting, status", user, 0);
                return;
            end
            want = pending.pop_front();
            status_seen[want.status]++;
            if (user != want.status)
                report("status", user, want.status);
            if (data[FIRST_W-1:0] != want.first_blk)
                report("first_block", data[FIRST_W-1:0], want.first_blk);
            if (data[FIRST_W+FREE_W-1:FIRST_W] != want.free_cnt)
                report("free_blocks", data[FIRST_W+FREE_W-1:FIRST_W], want.free_cnt);
        endtask
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;
    logic [S_TUSER_W-1:0]    s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic [M_TUSER_W-1:0]    m_tuser;

    bitmap_scoreboard sb = new();
    bit               no_idle;
    int               requests_sent;
    int               results_seen;
    int               cycle_count;

    int unsigned phase_bsize [NUM_PHASES] = '{64, 1, 4096, 37, 512};
    int unsigned phase_bcount [NUM_PHASES] = '{32, 100, 16, 200, 1024};
    int unsigned phase_items [NUM_PHASES] = '{160, 140, 110, 110, 40};
    bit          phase_quiet [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0};

    bitmap_first_fit_block_allocator #(
        .MAX_BLOCKS(MAP_DEPTH)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // mostly back to back, some short gaps, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic write_regs(input logic [BSIZE_W-1:0] bs, input logic [BCOUNT_W-1:0] bc);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_BLOCK_SIZE;
        cfg_data <= CFG_DATA_W'(bs);
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(CFG_BLOCK_SIZE, CFG_DATA_W'(bs));
        cfg_index <= CFG_BLOCK_COUNT;
        cfg_data <= CFG_DATA_W'(bc);
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(CFG_BLOCK_COUNT, CFG_DATA_W'(bc));
        cfg_valid <= 1'b0;
    endtask

    // stop offering, let every owed result come back, then change the setting
    task automatic reconfigure(input logic [BSIZE_W-1:0] bs, input logic [BCOUNT_W-1:0] bc);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        write_regs(bs, bc);
    endtask

    task automatic offer_request(input logic [ACTION_W-1:0] act,
                                 input logic [LENGTH_W-1:0] len,
                                 input logic [INDEX_W-1:0] idx);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {{PAD_W{1'b0}}, idx, len};
        do @(posedge aclk); while (!s_tready);
        sb.predict_request(act, len, idx);
        requests_sent++;
    endtask

    // mostly sized allocations and releases of used blocks, with noise mixed in
    task automatic random_request();
        int unsigned         r, n, need, eff_bs, alloc_pct;
        logic [ACTION_W-1:0] act;
        logic [LENGTH_W-1:0] len;
        logic [INDEX_W-1:0]  idx;
        n = sb.live_count();
        eff_bs = (sb.bsize == 0) ? 1 : sb.bsize;
        // lean toward releases when the map is nearly full
        alloc_pct = (sb.free_count() * 3 < n) ? 25 : 45;
        len = LENGTH_W'($urandom);
        idx = INDEX_W'($urandom);
        act = ACT_COUNT;
        r = $urandom_range(0, 99);
        if (r < alloc_pct) begin
            act = ACT_ALLOC;
            r = $urandom_range(0, 9);
            if (r < 6)
                need = $urandom_range(1, 4);
            else if (r < 9)
                need = $urandom_range(1, (n > 4) ? n / 4 : 1);
            else
                need = $urandom_range(1, n + 2);
            len = LENGTH_W'(need * eff_bs - $urandom_range(0, eff_bs - 1));
        end else if (r < alloc_pct + 5) begin
            // empty request or a length over the whole field
            act = ACT_ALLOC;
            if ($urandom_range(0, 1) == 0) len = '0;
        end else if (r < alloc_pct + 35) begin
            act = ACT_RELEASE;
            idx = INDEX_W'(sb.pick_used(n));
        end else if (r < alloc_pct + 42) begin
            act = ACT_RELEASE;
        end else if (r >= 97) begin
            act = ACT_UNUSED;
        end
        offer_request(act, len, idx);
    endtask

    // result side: random gaps plus two long hold-offs that back the block up
    initial begin : result_sink
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = idle_gap();
            if (results_seen == 60 || results_seen == 250)
                gap = LONG_HOLD;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tuser);
            results_seen++;
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_BLOCK_SIZE;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        no_idle = 1'b0;
        requests_sent = 0;
        results_seen = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset setting: 64 byte blocks, full map
        offer_request(ACT_ALLOC, 23'd0, 10'd0);          // empty request
        offer_request(ACT_ALLOC, 23'd1, 10'd0);          // one byte, block 0
        offer_request(ACT_ALLOC, 23'd64, 10'd0);         // exactly one block
        offer_request(ACT_ALLOC, 23'd65, 10'd0);         // rounds up to two
        offer_request(ACT_COUNT, 23'd0, 10'd0);
        offer_request(ACT_UNUSED, 23'h7fffff, 10'h3ff);  // undefined action, all ones
        offer_request(ACT_RELEASE, 23'h7fffff, 10'd1);   // release a used block
        offer_request(ACT_RELEASE, 23'd0, 10'd1);        // release it again, already free
        offer_request(ACT_ALLOC, 23'd128, 10'h3ff);      // hole at 1 too short
        offer_request(ACT_ALLOC, 23'h7fffff, 10'd0);     // far longer than the map
        offer_request(ACT_RELEASE, 23'd0, 10'h3ff);      // top index, free
        offer_request(ACT_ALLOC, 23'd65536, 10'd0);      // whole map, not all free
        offer_request(ACT_ALLOC, 23'd1, 10'd0);          // fills the hole at 1

        // zero block size acts as one byte, tiny map over already used bits
        reconfigure(13'd0, 11'd8);
        offer_request(ACT_ALLOC, 23'd2, 10'd0);
        offer_request(ACT_ALLOC, 23'd1, 10'd0);          // map full, no space
        offer_request(ACT_RELEASE, 23'd0, 10'd8);        // just past the live count
        offer_request(ACT_RELEASE, 23'd0, 10'h3ff);
        offer_request(ACT_RELEASE, 23'd0, 10'd7);

        // no blocks at all, largest block size
        reconfigure(13'h1fff, 11'd0);
        offer_request(ACT_ALLOC, 23'h1fff, 10'd0);
        offer_request(ACT_COUNT, 23'd0, 10'd0);
        offer_request(ACT_RELEASE, 23'd0, 10'd0);

        // count above the map depth clamps to the full map
        reconfigure(13'd1, 11'h7ff);
        offer_request(ACT_ALLOC, 23'd1017, 10'd0);       // exactly the free tail
        offer_request(ACT_COUNT, 23'd0, 10'd0);
        offer_request(ACT_RELEASE, 23'd0, 10'd1000);
        offer_request(ACT_ALLOC, 23'd1, 10'd0);

        // random phases; most use small maps to keep scans short
        for (int p = 0; p < NUM_PHASES; p++) begin
            reconfigure(BSIZE_W'(phase_bsize[p]), BCOUNT_W'(phase_bcount[p]));
            no_idle = phase_quiet[p];
            for (int k = 0; k < phase_items[p]; k++)
                random_request();
        end
        no_idle = 1'b0;

        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        // any late extra result still gets caught by the sink
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("summary: %0d requests over %0d settings, %0d results checked, %0d mismatches",
                 requests_sent, NUM_PHASES + 4, sb.checked, sb.errors);
        $display("summary: ok %0d, no space %0d, empty %0d, out of range %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_NO_SPACE],
                 sb.status_seen[ST_EMPTY], sb.status_seen[ST_RANGE]);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
